### rtl/shs_pkg.sv
// shared types, constants and codes of the stepper homing sequencer
package shs_pkg;

   localparam int ADC_BITS         = 10;
   localparam int POS_BITS         = 32;
   localparam int FILTER_FRAC_BITS = 10;
   localparam int STEPS_BITS       = 20;
   localparam int MOTION_BITS      = 16;
   localparam int PHASE_BITS       = 4;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 32;

   localparam int ACC_BITS  = ADC_BITS + FILTER_FRAC_BITS;
   localparam int PROD_BITS = ACC_BITS + FILTER_FRAC_BITS + 2;
   localparam int ADC_MAX   = (1 << ADC_BITS) - 1;

   // 0.8 in Q(FILTER_FRAC_BITS), truncated
   localparam logic [FILTER_FRAC_BITS-1:0] FILT_COEF =
      FILTER_FRAC_BITS'((4 << FILTER_FRAC_BITS) / 5);
   localparam logic [ADC_BITS-1:0] MARK_HIGH = ADC_BITS'((2 * ADC_MAX) / 5 + 1);
   localparam logic [ADC_BITS-1:0] MARK_LOW  = ADC_BITS'((ADC_MAX - 1) / 5);

   localparam logic signed [POS_BITS-1:0] RST_CAL_OFFSET = '0;
   localparam logic [STEPS_BITS-1:0]  RST_COARSE_STEPS = STEPS_BITS'(32000);
   localparam logic [STEPS_BITS-1:0]  RST_FINE_STEPS   = STEPS_BITS'(6400);
   localparam logic [MOTION_BITS-1:0] RST_SEARCH_SPEED = MOTION_BITS'(1500);
   localparam logic [MOTION_BITS-1:0] RST_SEARCH_ACCEL = MOTION_BITS'(4000);
   localparam logic [MOTION_BITS-1:0] RST_CRUISE_SPEED = MOTION_BITS'(7000);
   localparam logic [MOTION_BITS-1:0] RST_CRUISE_ACCEL = MOTION_BITS'(8000);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CAL_OFFSET   = 3'd0,
      REG_COARSE_STEPS = 3'd1,
      REG_FINE_STEPS   = 3'd2,
      REG_SEARCH_SPEED = 3'd3,
      REG_SEARCH_ACCEL = 3'd4,
      REG_CRUISE_SPEED = 3'd5,
      REG_CRUISE_ACCEL = 3'd6
   } reg_index_type;

   typedef enum logic [PHASE_BITS-1:0] {
      PH_IDLE         = 4'd0,
      PH_AWAY_SETUP   = 4'd1,
      PH_AWAY_WAIT    = 4'd2,
      PH_COARSE_SETUP = 4'd3,
      PH_COARSE_SWEEP = 4'd4,
      PH_COARSE_HALT  = 4'd5,
      PH_FINE_SETUP   = 4'd6,
      PH_FINE_SWEEP   = 4'd7,
      PH_FINE_HALT    = 4'd8,
      PH_CALIBRATE    = 4'd9,
      PH_AT_ZERO      = 4'd10
   } phase_type;

   typedef enum logic {
      REQ_TICK  = 1'b0,
      REQ_START = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic signed [POS_BITS-1:0] calibration_offset;
      logic [STEPS_BITS-1:0]      coarse_sweep_steps;
      logic [STEPS_BITS-1:0]      fine_sweep_steps;
      logic [MOTION_BITS-1:0]     search_speed;
      logic [MOTION_BITS-1:0]     search_accel;
      logic [MOTION_BITS-1:0]     cruise_speed;
      logic [MOTION_BITS-1:0]     cruise_accel;
   } cfg_type;

   typedef struct packed {
      logic                       req_type;
      logic [ADC_BITS-1:0]        sensor_a;
      logic [ADC_BITS-1:0]        sensor_b;
      logic signed [POS_BITS-1:0] motor_position;
      logic signed [POS_BITS-1:0] motor_goal;
      logic                       motor_running;
   } req_item_type;

   typedef struct packed {
      logic                       apply_motion;
      logic [MOTION_BITS-1:0]     motion_speed;
      logic [MOTION_BITS-1:0]     motion_accel;
      logic                       apply_reset;
      logic signed [POS_BITS-1:0] reset_value;
      logic                       apply_goal;
      logic signed [POS_BITS-1:0] goal_value;
      logic                       halt_motor;
      logic                       homing_done;
      logic [PHASE_BITS-1:0]      phase_now;
   } rsp_item_type;

   // filter update strobes from the sequencer
   typedef struct packed {
      logic upd_a;
      logic upd_b;
   } filt_ctl_type;

   typedef struct packed {
      logic [ADC_BITS-1:0] count_a;
      logic [ADC_BITS-1:0] count_b;
   } filt_stat_type;

endpackage

### rtl/shs_channels.sv
// request, response and register write channel interfaces
interface shs_req_if;
   logic                                         valid;
   logic                                         ready;
   logic                                         req_type;
   logic [shs_pkg::ADC_BITS-1:0]                 sensor_a;
   logic [shs_pkg::ADC_BITS-1:0]                 sensor_b;
   logic signed [shs_pkg::POS_BITS-1:0]          motor_position;
   logic signed [shs_pkg::POS_BITS-1:0]          motor_goal;
   logic                                         motor_running;

   modport source(output valid, req_type, sensor_a, sensor_b, motor_position, motor_goal,
                  motor_running, input ready);
   modport sink(input valid, req_type, sensor_a, sensor_b, motor_position, motor_goal,
                motor_running, output ready);
endinterface

interface shs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                apply_motion;
   logic [shs_pkg::MOTION_BITS-1:0]     motion_speed;
   logic [shs_pkg::MOTION_BITS-1:0]     motion_accel;
   logic                                apply_reset;
   logic signed [shs_pkg::POS_BITS-1:0] reset_value;
   logic                                apply_goal;
   logic signed [shs_pkg::POS_BITS-1:0] goal_value;
   logic                                halt_motor;
   logic                                homing_done;
   logic [shs_pkg::PHASE_BITS-1:0]      phase_now;

   modport source(output valid, apply_motion, motion_speed, motion_accel, apply_reset,
                  reset_value, apply_goal, goal_value, halt_motor, homing_done, phase_now,
                  input ready);
   modport sink(input valid, apply_motion, motion_speed, motion_accel, apply_reset,
                reset_value, apply_goal, goal_value, halt_motor, homing_done, phase_now,
                output ready);
endinterface

interface shs_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [shs_pkg::CSR_INDEX_BITS-1:0]   index;
   logic [shs_pkg::CSR_DATA_BITS-1:0]    data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

### rtl/shs_csr_regs.sv
// configuration register file of the homing sequencer
module shs_csr_regs (
   input  logic             clock,
   input  logic             reset,
   shs_csr_if.sink          csr_ch,
   output shs_pkg::cfg_type cfg
);

   shs_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (shs_pkg::reg_index_type'(csr_ch.index))
            shs_pkg::REG_CAL_OFFSET:
               cfg_in.calibration_offset = shs_pkg::POS_BITS'(csr_ch.data);
            shs_pkg::REG_COARSE_STEPS:
               cfg_in.coarse_sweep_steps = shs_pkg::STEPS_BITS'(csr_ch.data);
            shs_pkg::REG_FINE_STEPS:
               cfg_in.fine_sweep_steps = shs_pkg::STEPS_BITS'(csr_ch.data);
            shs_pkg::REG_SEARCH_SPEED:
               cfg_in.search_speed = shs_pkg::MOTION_BITS'(csr_ch.data);
            shs_pkg::REG_SEARCH_ACCEL:
               cfg_in.search_accel = shs_pkg::MOTION_BITS'(csr_ch.data);
            shs_pkg::REG_CRUISE_SPEED:
               cfg_in.cruise_speed = shs_pkg::MOTION_BITS'(csr_ch.data);
            shs_pkg::REG_CRUISE_ACCEL:
               cfg_in.cruise_accel = shs_pkg::MOTION_BITS'(csr_ch.data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.calibration_offset <= shs_pkg::RST_CAL_OFFSET;
         cfg_ff.coarse_sweep_steps <= shs_pkg::RST_COARSE_STEPS;
         cfg_ff.fine_sweep_steps   <= shs_pkg::RST_FINE_STEPS;
         cfg_ff.search_speed       <= shs_pkg::RST_SEARCH_SPEED;
         cfg_ff.search_accel       <= shs_pkg::RST_SEARCH_ACCEL;
         cfg_ff.cruise_speed       <= shs_pkg::RST_CRUISE_SPEED;
         cfg_ff.cruise_accel       <= shs_pkg::RST_CRUISE_ACCEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/shs_filter.sv
// first-order running filter of one marker sensor
module shs_filter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         update,
   input  logic [shs_pkg::ADC_BITS-1:0] sample,
   output logic [shs_pkg::ADC_BITS-1:0] count
);

   logic [shs_pkg::ACC_BITS-1:0]         acc_ff, acc_in;
   logic [shs_pkg::ACC_BITS-1:0]         acc_next;
   logic signed [shs_pkg::ACC_BITS:0]    diff;
   logic signed [shs_pkg::PROD_BITS-1:0] prod;
   logic signed [shs_pkg::PROD_BITS-1:0] step;

   always_comb begin
      diff = $signed({1'b0, sample, {shs_pkg::FILTER_FRAC_BITS{1'b0}}})
             - $signed({1'b0, acc_ff});
      prod = shs_pkg::PROD_BITS'(diff)
             * shs_pkg::PROD_BITS'($signed({1'b0, shs_pkg::FILT_COEF}));
      // arithmetic shift floors negative steps too
      step = prod >>> shs_pkg::FILTER_FRAC_BITS;
      acc_next = acc_ff + step[shs_pkg::ACC_BITS-1:0];
      acc_in = update ? acc_next : acc_ff;
   end

   assign count = acc_next[shs_pkg::ACC_BITS-1:shs_pkg::FILTER_FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

### rtl/shs_seq_core.sv
// homing phase state machine and response formation
module shs_seq_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  shs_pkg::req_item_type  req,
   input  shs_pkg::cfg_type       cfg,
   input  shs_pkg::filt_stat_type filt_stat,
   output shs_pkg::filt_ctl_type  filt_ctl,
   output shs_pkg::rsp_item_type  rsp
);

   shs_pkg::phase_type phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= shs_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      rsp = '0;
      filt_ctl = '0;
      phase_in = phase_ff;
      if (step) begin
         if (req.req_type == shs_pkg::REQ_START) begin
            rsp.apply_reset = 1'b1;
            rsp.reset_value = '0;
            phase_in = shs_pkg::PH_AWAY_SETUP;
         end else begin
            case (phase_ff)
               shs_pkg::PH_AWAY_SETUP: begin
                  rsp.apply_goal = 1'b1;
                  rsp.goal_value = req.motor_position
                                   - shs_pkg::POS_BITS'(cfg.coarse_sweep_steps);
                  phase_in = shs_pkg::PH_AWAY_WAIT;
               end
               shs_pkg::PH_AWAY_WAIT: begin
                  filt_ctl.upd_a = 1'b1;
                  if (filt_stat.count_a <= shs_pkg::MARK_LOW) begin
                     phase_in = shs_pkg::PH_COARSE_SETUP;
                  end
               end
               shs_pkg::PH_COARSE_SETUP: begin
                  rsp.apply_motion = 1'b1;
                  rsp.motion_speed = cfg.search_speed;
                  rsp.motion_accel = cfg.search_accel;
                  rsp.apply_goal = 1'b1;
                  rsp.goal_value = req.motor_position
                                   + shs_pkg::POS_BITS'(cfg.coarse_sweep_steps);
                  phase_in = shs_pkg::PH_COARSE_SWEEP;
               end
               shs_pkg::PH_COARSE_SWEEP: begin
                  filt_ctl.upd_a = 1'b1;
                  if (filt_stat.count_a >= shs_pkg::MARK_HIGH) begin
                     rsp.halt_motor = 1'b1;
                     phase_in = shs_pkg::PH_COARSE_HALT;
                  end
               end
               shs_pkg::PH_COARSE_HALT: begin
                  if (!req.motor_running) begin
                     phase_in = shs_pkg::PH_FINE_SETUP;
                  end
               end
               shs_pkg::PH_FINE_SETUP: begin
                  rsp.apply_motion = 1'b1;
                  rsp.motion_speed = cfg.search_speed;
                  rsp.motion_accel = cfg.search_accel;
                  rsp.apply_goal = 1'b1;
                  rsp.goal_value = req.motor_position
                                   + shs_pkg::POS_BITS'(cfg.fine_sweep_steps);
                  phase_in = shs_pkg::PH_FINE_SWEEP;
               end
               shs_pkg::PH_FINE_SWEEP: begin
                  filt_ctl.upd_b = 1'b1;
                  if (filt_stat.count_b >= shs_pkg::MARK_HIGH) begin
                     rsp.halt_motor = 1'b1;
                     phase_in = shs_pkg::PH_FINE_HALT;
                  end
               end
               shs_pkg::PH_FINE_HALT: begin
                  if (!req.motor_running) begin
                     phase_in = shs_pkg::PH_CALIBRATE;
                  end
               end
               shs_pkg::PH_CALIBRATE: begin
                  rsp.apply_reset = 1'b1;
                  rsp.reset_value = cfg.calibration_offset;
                  rsp.apply_goal = 1'b1;
                  rsp.goal_value = '0;
                  phase_in = shs_pkg::PH_AT_ZERO;
               end
               shs_pkg::PH_AT_ZERO: begin
                  if (req.motor_position == req.motor_goal) begin
                     rsp.apply_motion = 1'b1;
                     rsp.motion_speed = cfg.cruise_speed;
                     rsp.motion_accel = cfg.cruise_accel;
                     rsp.homing_done = 1'b1;
                     phase_in = shs_pkg::PH_IDLE;
                  end
               end
               default: begin
                  phase_in = shs_pkg::PH_IDLE;
               end
            endcase
         end
      end
      rsp.phase_now = phase_in;
   end

endmodule

### rtl/stepper_homing_sequencer.sv
// stepper homing sequencer top level: request register, sequencer, response register
// a held request's response is registered when the response register is free or draining
// throughput: one request per cycle while rsp_ch is ready; the request and response
//   registers form a two-deep pipe; a request is taken while a response waits on rsp_ch
// reset: synchronous active high; phase returns to idle, both filter accumulators clear,
//   configuration registers take their defaults and both pipe stages empty
module stepper_homing_sequencer (
   input  logic       clock,
   input  logic       reset,
   shs_req_if.sink    req_ch,
   shs_rsp_if.source  rsp_ch,
   shs_csr_if.sink    csr_ch
);

   // request register stage
   logic                  in_valid_ff, in_valid_in;
   shs_pkg::req_item_type in_item_ff, in_item_in;

   // response register stage
   logic                  out_valid_ff, out_valid_in;
   shs_pkg::rsp_item_type out_item_ff, out_item_in;

   logic                   accept;
   logic                   advance;
   shs_pkg::cfg_type       cfg;
   shs_pkg::rsp_item_type  core_rsp;
   shs_pkg::filt_ctl_type  filt_ctl;
   shs_pkg::filt_stat_type filt_stat;

   // the held request moves on whenever the response register is empty or draining
   assign advance = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in = in_item_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_item_in.req_type = req_ch.req_type;
         in_item_in.sensor_a = req_ch.sensor_a;
         in_item_in.sensor_b = req_ch.sensor_b;
         in_item_in.motor_position = req_ch.motor_position;
         in_item_in.motor_goal = req_ch.motor_goal;
         in_item_in.motor_running = req_ch.motor_running;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in = out_item_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in = core_rsp;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_item_ff <= out_item_in;
   end

   // configuration registers
   shs_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // marker a filter, stepped only in the away wait and coarse sweep phases
   shs_filter u_filt_a (
      .clock  (clock),
      .reset  (reset),
      .update (filt_ctl.upd_a),
      .sample (in_item_ff.sensor_a),
      .count  (filt_stat.count_a)
   );

   // marker b filter, stepped only in the fine sweep phase
   shs_filter u_filt_b (
      .clock  (clock),
      .reset  (reset),
      .update (filt_ctl.upd_b),
      .sample (in_item_ff.sensor_b),
      .count  (filt_stat.count_b)
   );

   // phase machine; state moves only when the held request advances
   shs_seq_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .req       (in_item_ff),
      .cfg       (cfg),
      .filt_stat (filt_stat),
      .filt_ctl  (filt_ctl),
      .rsp       (core_rsp)
   );

   // response port
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.apply_motion = out_item_ff.apply_motion;
   assign rsp_ch.motion_speed = out_item_ff.motion_speed;
   assign rsp_ch.motion_accel = out_item_ff.motion_accel;
   assign rsp_ch.apply_reset = out_item_ff.apply_reset;
   assign rsp_ch.reset_value = out_item_ff.reset_value;
   assign rsp_ch.apply_goal = out_item_ff.apply_goal;
   assign rsp_ch.goal_value = out_item_ff.goal_value;
   assign rsp_ch.halt_motor = out_item_ff.halt_motor;
   assign rsp_ch.homing_done = out_item_ff.homing_done;
   assign rsp_ch.phase_now = out_item_ff.phase_now;

   // done is only reported together with the cruise motion and a return to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.homing_done |->
         out_item_ff.apply_motion && out_item_ff.phase_now == shs_pkg::PH_IDLE)
      else $error("homing done without idle phase and cruise motion");

   // a halt only ends one of the two marker sweeps
   a_halt_phase: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.halt_motor |->
         out_item_ff.phase_now == shs_pkg::PH_COARSE_HALT ||
         out_item_ff.phase_now == shs_pkg::PH_FINE_HALT)
      else $error("halt outside a marker sweep");

   // a counter reset with a goal is the calibration step, which aims at zero
   a_calib_goal: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.apply_reset && out_item_ff.apply_goal |->
         out_item_ff.goal_value == '0 && out_item_ff.phase_now == shs_pkg::PH_AT_ZERO)
      else $error("calibration goal not zero");

   // filters step only while a request moves into the response register
   a_filter_step: assert property (@(posedge clock) disable iff (reset)
      (filt_ctl.upd_a || filt_ctl.upd_b) |-> advance && !(filt_ctl.upd_a && filt_ctl.upd_b))
      else $error("filter stepped without a request");

endmodule
